// File: hw/rtl/msm_pkg.sv
package msm_pkg;

    // field widths of the words on both channels
    localparam int ACTION_W = 2;
    localparam int STATE_W  = 4;
    localparam int WEIGHT_W = 14;
    localparam int DRAW_W   = 14;
    localparam int COUNT_W  = 5;

    // state_count after reset
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    // width of the shift count used by the draw reduction
    localparam int RED_K_W = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_TRANS = 2'd0,
        ACT_LOAD_INIT  = 2'd1,
        ACT_START      = 2'd2,
        ACT_STEP       = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // control strobes from the sequencer to the weight memory
    typedef struct packed {
        logic we;       // write one weight
        logic wr_init;  // write goes to the initial weights
        logic rd_init;  // read comes from the initial weights
    } t_mem_ctl;

endpackage

// File: hw/rtl/msm_if.sv
// input channel: one load, start or step request per word
interface msm_in_if;
    logic                          valid;
    logic                          ready;
    logic [msm_pkg::ACTION_W-1:0]  action;
    logic [msm_pkg::STATE_W-1:0]   from_state;
    logic [msm_pkg::STATE_W-1:0]   to_state;
    logic [msm_pkg::WEIGHT_W-1:0]  weight;
    logic [msm_pkg::DRAW_W-1:0]    random_value;

    modport source (output valid, action, from_state, to_state, weight, random_value,
                    input ready);
    modport sink   (input valid, action, from_state, to_state, weight, random_value,
                    output ready);
endinterface

// output channel: one sampled state per word
interface msm_out_if;
    logic                         valid;
    logic                         ready;
    logic [msm_pkg::STATE_W-1:0]  chosen_state;
    logic                         fallback_used;

    modport source (output valid, chosen_state, fallback_used, input ready);
    modport sink   (input valid, chosen_state, fallback_used, output ready);
endinterface

// File: hw/rtl/msm_wmem.sv
module msm_wmem #(
    parameter int MAX_STATES = 16
) (
    input  logic                                i_clk,
    input  msm_pkg::t_mem_ctl                   i_ctl,
    input  logic [$clog2(MAX_STATES)-1:0]       i_wrow,
    input  logic [$clog2(MAX_STATES)-1:0]       i_wcol,
    input  logic [msm_pkg::WEIGHT_W-1:0]        i_wdata,
    input  logic [$clog2(MAX_STATES)-1:0]       i_rrow,
    input  logic [$clog2(MAX_STATES)-1:0]       i_rcol,
    output logic [msm_pkg::WEIGHT_W-1:0]        o_rdata
);

    localparam int AW    = $clog2(MAX_STATES * MAX_STATES);

    logic [msm_pkg::WEIGHT_W-1:0] r_trans_mem [MAX_STATES*MAX_STATES];
    logic [msm_pkg::WEIGHT_W-1:0] r_init_mem  [MAX_STATES];
    logic [msm_pkg::WEIGHT_W-1:0] r_trans_q;
    logic [msm_pkg::WEIGHT_W-1:0] r_init_q;
    logic                         r_rd_init_q;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;

    // row-major flat addresses into the transition table
    assign waddr = AW'(i_wrow) * AW'(MAX_STATES) + AW'(i_wcol);
    assign raddr = AW'(i_rrow) * AW'(MAX_STATES) + AW'(i_rcol);

    // transition weights: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.we && !i_ctl.wr_init) begin
            r_trans_mem[waddr] <= i_wdata;
        end
        r_trans_q <= r_trans_mem[raddr];
    end

    // initial weights
    always_ff @(posedge i_clk) begin
        if (i_ctl.we && i_ctl.wr_init) begin
            r_init_mem[i_wcol] <= i_wdata;
        end
        r_init_q <= r_init_mem[i_rcol];
    end

    always_ff @(posedge i_clk) begin
        r_rd_init_q <= i_ctl.rd_init;
    end

    assign o_rdata = r_rd_init_q ? r_init_q : r_trans_q;

endmodule

// File: hw/rtl/msm_ctrl.sv
module msm_ctrl #(
    parameter int MAX_STATES = 16,
    parameter int PROB_SCALE = 10000,
    parameter int N_W        = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [N_W-1:0]                      i_n,
    msm_in_if.sink                              i_in,
    msm_out_if.source                           o_out,
    output msm_pkg::t_mem_ctl                   o_mem_ctl,
    output logic [$clog2(MAX_STATES)-1:0]       o_wrow,
    output logic [$clog2(MAX_STATES)-1:0]       o_wcol,
    output logic [msm_pkg::WEIGHT_W-1:0]        o_wdata,
    output logic [$clog2(MAX_STATES)-1:0]       o_rrow,
    output logic [$clog2(MAX_STATES)-1:0]       o_rcol,
    input  logic [msm_pkg::WEIGHT_W-1:0]        i_rdata
);

    // largest k with PROB_SCALE << k still inside the draw range
    function automatic int f_red_top(input int scale);
        int k;
        k = 0;
        for (int j = 1; j < msm_pkg::DRAW_W; j++) begin
            if ((longint'(scale) << j) <= ((longint'(1) << msm_pkg::DRAW_W) - 1)) begin
                k = j;
            end
        end
        return k;
    endfunction

    localparam int IDX_W   = $clog2(MAX_STATES);
    localparam int CMP_W   = (IDX_W > N_W) ? IDX_W : N_W;
    localparam int SUM_W   = msm_pkg::WEIGHT_W + N_W;
    localparam int MULT_W  = msm_pkg::DRAW_W + 16;
    localparam int RED_TOP = f_red_top(PROB_SCALE);
    localparam logic [MULT_W-1:0] SCALE_M = MULT_W'(PROB_SCALE);

    msm_pkg::t_state r_state, n_state;

    logic [msm_pkg::DRAW_W-1:0]   r_draw,   n_draw;
    logic [msm_pkg::RED_K_W-1:0]  r_k,      n_k;
    logic                         r_start,  n_start;
    logic [IDX_W-1:0]             r_row,    n_row;
    logic [IDX_W-1:0]             r_i,      n_i;
    logic [SUM_W-1:0]             r_sum,    n_sum;
    logic [msm_pkg::STATE_W-1:0]  r_pick,   n_pick;
    logic                         r_fb,     n_fb;
    logic [msm_pkg::STATE_W-1:0]  r_cur,    n_cur;
    logic                         r_ovalid, n_ovalid;
    logic [msm_pkg::STATE_W-1:0]  r_ostate, n_ostate;
    logic                         r_ofb,    n_ofb;

    logic                         in_acc;
    logic                         is_sample;
    logic                         row_ok;
    logic                         col_ok;
    logic                         red_done;
    logic                         out_free;
    logic [MULT_W-1:0]            multiple;
    logic                         draw_ge;
    logic [SUM_W-1:0]             sum_next;
    logic                         hit;
    logic                         last;
    logic [msm_pkg::STATE_W-1:0]  fb_pick;
    msm_pkg::t_action             act;

    assign act       = msm_pkg::t_action'(i_in.action);
    assign i_in.ready = (r_state == msm_pkg::ST_IDLE);
    assign in_acc    = i_in.valid && i_in.ready;
    assign is_sample = (act == msm_pkg::ACT_START) || (act == msm_pkg::ACT_STEP);
    assign row_ok    = 7'(i_in.from_state) < 7'(MAX_STATES);
    assign col_ok    = 7'(i_in.to_state) < 7'(MAX_STATES);

    // draw reduction: compare and subtract one shifted multiple per cycle
    assign multiple  = SCALE_M << r_k;
    assign draw_ge   = MULT_W'(r_draw) >= multiple;
    assign red_done  = (r_k == '0);

    // running sum against the reduced draw; memory data is entry r_i
    assign sum_next  = r_sum + SUM_W'(i_rdata);
    assign hit       = SUM_W'(r_draw) < sum_next;
    assign last      = CMP_W'(r_i) == CMP_W'(i_n - 1'b1);
    assign fb_pick   = r_start ? msm_pkg::STATE_W'(i_n - 1'b1) : '0;

    assign out_free  = !r_ovalid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            msm_pkg::ST_IDLE: begin
                if (in_acc && is_sample) begin
                    n_state = (i_n == '0) ? msm_pkg::ST_FINISH : msm_pkg::ST_REDUCE;
                end
            end
            msm_pkg::ST_REDUCE: begin
                if (red_done) begin
                    n_state = msm_pkg::ST_SCAN;
                end
            end
            msm_pkg::ST_SCAN: begin
                if (hit || last) begin
                    n_state = msm_pkg::ST_FINISH;
                end
            end
            msm_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = msm_pkg::ST_IDLE;
                end
            end
            default: n_state = msm_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_draw   = r_draw;
        n_k      = r_k;
        n_start  = r_start;
        n_row    = r_row;
        n_i      = r_i;
        n_sum    = r_sum;
        n_pick   = r_pick;
        n_fb     = r_fb;
        n_cur    = r_cur;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ostate = r_ostate;
        n_ofb    = r_ofb;

        o_mem_ctl.we      = 1'b0;
        o_mem_ctl.wr_init = (act == msm_pkg::ACT_LOAD_INIT);
        o_mem_ctl.rd_init = r_start;
        o_wrow  = IDX_W'(i_in.from_state);
        o_wcol  = IDX_W'(i_in.to_state);
        o_wdata = i_in.weight;
        o_rrow  = r_row;
        o_rcol  = (r_state == msm_pkg::ST_SCAN) ? IDX_W'(r_i + 1'b1) : '0;

        case (r_state)
            msm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (act)
                        msm_pkg::ACT_LOAD_TRANS: o_mem_ctl.we = row_ok && col_ok;
                        msm_pkg::ACT_LOAD_INIT:  o_mem_ctl.we = col_ok;
                        default:                 o_mem_ctl.we = 1'b0;
                    endcase
                    if (is_sample) begin
                        n_draw  = i_in.random_value;
                        n_k     = msm_pkg::RED_K_W'(RED_TOP);
                        n_start = (act == msm_pkg::ACT_START);
                        n_row   = (7'(r_cur) < 7'(MAX_STATES)) ? IDX_W'(r_cur) : '0;
                        n_i     = '0;
                        n_sum   = '0;
                        // no states in use: state 0 with fallback
                        n_pick  = '0;
                        n_fb    = 1'b1;
                    end
                end
            end
            msm_pkg::ST_REDUCE: begin
                if (draw_ge) begin
                    n_draw = r_draw - msm_pkg::DRAW_W'(multiple);
                end
                if (!red_done) begin
                    n_k = r_k - 1'b1;
                end
            end
            msm_pkg::ST_SCAN: begin
                n_sum = sum_next;
                n_i   = IDX_W'(r_i + 1'b1);
                if (hit) begin
                    n_pick = msm_pkg::STATE_W'(r_i);
                    n_fb   = 1'b0;
                end else if (last) begin
                    n_pick = fb_pick;
                    n_fb   = 1'b1;
                end
            end
            msm_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostate = r_pick;
                    n_ofb    = r_fb;
                    n_cur    = r_pick;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msm_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_cur    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cur    <= n_cur;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_draw   <= n_draw;
        r_k      <= n_k;
        r_start  <= n_start;
        r_row    <= n_row;
        r_i      <= n_i;
        r_sum    <= n_sum;
        r_pick   <= n_pick;
        r_fb     <= n_fb;
        r_ostate <= n_ostate;
        r_ofb    <= n_ofb;
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.chosen_state  = r_ostate;
    assign o_out.fallback_used = r_ofb;

endmodule

// File: hw/rtl/markov_state_sampler.sv
// Markov chain state sampler. Load words write one transition weight (row from_state,
// column to_state) or one initial weight (column to_state) into on-chip memory; loads
// give no result word. A start word samples the initial weights and a step word samples
// the current state's row: the weights are read from memory one per cycle and summed,
// and the first state whose running sum exceeds the draw (taken modulo PROB_SCALE)
// wins. With no winner, start returns the last state in use and step returns state 0,
// with fallback_used set. A start or step word passes through the draw reduction, the
// memory scan, which stops once the running sum passes the draw, and the finish state
// (reduction and scan are skipped when no state is in use); no new word is accepted
// until it is done, and the single-read-port memory scan sets the pace. The next word
// is accepted while a finished result still waits in the output register. Weights must
// be loaded before they are sampled; state_count must be written only while idle, and
// the block itself does not enforce this.
module markov_state_sampler #(
    parameter int MAX_STATES = 16,
    parameter int PROB_SCALE = 10000
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [msm_pkg::COUNT_W-1:0]    i_cfg_wdata,
    msm_in_if.sink                         i_in,
    msm_out_if.source                      o_out
);

    localparam int IDX_W = $clog2(MAX_STATES);
    localparam int N_MAX = (MAX_STATES < 31) ? MAX_STATES : 31;
    localparam int N_W   = $clog2(N_MAX + 1);

    logic [msm_pkg::COUNT_W-1:0]  r_state_count;
    logic [N_W-1:0]               n_use;
    msm_pkg::t_mem_ctl            mem_ctl;
    logic [IDX_W-1:0]             wrow;
    logic [IDX_W-1:0]             wcol;
    logic [msm_pkg::WEIGHT_W-1:0] wdata;
    logic [IDX_W-1:0]             rrow;
    logic [IDX_W-1:0]             rcol;
    logic [msm_pkg::WEIGHT_W-1:0] rdata;

    // state_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= msm_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_state_count <= i_cfg_wdata;
        end
    end

    // states in use, capped at MAX_STATES (and at 31)
    assign n_use = (r_state_count > msm_pkg::COUNT_W'(N_MAX)) ? N_W'(N_MAX)
                                                              : N_W'(r_state_count);

    msm_ctrl #(
        .MAX_STATES (MAX_STATES),
        .PROB_SCALE (PROB_SCALE),
        .N_W        (N_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_n       (n_use),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mem_ctl (mem_ctl),
        .o_wrow    (wrow),
        .o_wcol    (wcol),
        .o_wdata   (wdata),
        .o_rrow    (rrow),
        .o_rcol    (rcol),
        .i_rdata   (rdata)
    );

    msm_wmem #(
        .MAX_STATES (MAX_STATES)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_wrow  (wrow),
        .i_wcol  (wcol),
        .i_wdata (wdata),
        .i_rrow  (rrow),
        .i_rcol  (rcol),
        .o_rdata (rdata)
    );

endmodule

// File: sim/tb_markov_state_sampler.sv
// one sampled state as it leaves the block
typedef struct packed {
    logic [msm_pkg::STATE_W-1:0] state;
    logic                        fallback;
} t_sample;

// Tracks the weight tables, current state and state count, and holds the
// samples still owed by the block, oldest first.
class sampler_scoreboard;
    localparam int N_STATES = 16;
    localparam int SCALE    = 10000;

    logic [msm_pkg::WEIGHT_W-1:0] trans_w [N_STATES][N_STATES];
    logic [msm_pkg::WEIGHT_W-1:0] init_w [N_STATES];
    logic [msm_pkg::STATE_W-1:0]  cur_state;
    logic [msm_pkg::COUNT_W-1:0]  count;
    t_sample                      owed_q[$];
    int                           mismatches;

    function new();
        cur_state  = '0;
        count      = msm_pkg::COUNT_RESET;
        mismatches = 0;
        for (int r = 0; r < N_STATES; r++) begin
            init_w[r] = '0;
            for (int c = 0; c < N_STATES; c++) trans_w[r][c] = '0;
        end
    endfunction

    function void set_count(logic [msm_pkg::COUNT_W-1:0] v);
        count = v;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // apply one accepted input word; start and step owe one sample
    function void note_word(msm_pkg::t_action act, logic [msm_pkg::STATE_W-1:0] from_st,
                            logic [msm_pkg::STATE_W-1:0] to_st,
                            logic [msm_pkg::WEIGHT_W-1:0] w,
                            logic [msm_pkg::DRAW_W-1:0] raw_draw);
        int      n;
        int      draw;
        int      sum;
        int      pick;
        t_sample s;
        n    = (int'(count) > N_STATES) ? N_STATES : int'(count);
        draw = int'(raw_draw) % SCALE;
        case (act)
            msm_pkg::ACT_LOAD_TRANS: begin
                trans_w[from_st][to_st] = w;
                return;
            end
            msm_pkg::ACT_LOAD_INIT: begin
                init_w[to_st] = w;
                return;
            end
            default: ;
        endcase
        // running sum over the states in use, first strict excess wins
        sum  = 0;
        pick = n;
        for (int i = 0; i < n; i++) begin
            sum += (act == msm_pkg::ACT_START) ? int'(init_w[i]) : int'(trans_w[cur_state][i]);
            if (draw < sum) begin
                pick = i;
                break;
            end
        end
        s.fallback = (pick >= n);
        if (!s.fallback)
            s.state = pick[msm_pkg::STATE_W-1:0];
        else if (act == msm_pkg::ACT_START && n != 0)
            s.state = msm_pkg::STATE_W'(n - 1);
        else
            s.state = '0;
        cur_state = s.state;
        owed_q.push_back(s);
    endfunction

    // compare one accepted output word with the oldest owed sample
    function void check_sample(logic [msm_pkg::STATE_W-1:0] st, logic fb);
        t_sample s;
        if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected sample: state %0d fallback %0b", st, fb);
            return;
        end
        s = owed_q.pop_front();
        if (s.state !== st || s.fallback !== fb) begin
            mismatches++;
            if (mismatches <= 10)
                $display("sample mismatch: expected state %0d fallback %0b, got %0d %0b",
                         s.state, s.fallback, st, fb);
        end
    endfunction
endclass

module tb_markov_state_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STATES    = 16;
    localparam int PROB_SCALE    = 10000;
    localparam int SETTLE_CYCLES = 2 * MAX_STATES + 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_WORDS   = 85;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [msm_pkg::COUNT_W-1:0]   i_cfg_wdata;

    msm_in_if  in_if();
    msm_out_if out_if();

    sampler_scoreboard sb = new();

    bit tx_idle_on;
    bit rx_idle_on;
    int hold_asked;
    int hold_given;
    int cycles;

    markov_state_sampler #(
        .MAX_STATES (MAX_STATES),
        .PROB_SCALE (PROB_SCALE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // watch both channels; results first, as none can belong to this edge's input
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_sample(out_if.chosen_state, out_if.fallback_used);
            if (in_if.valid && in_if.ready)
                sb.note_word(msm_pkg::t_action'(in_if.action), in_if.from_state,
                             in_if.to_state, in_if.weight, in_if.random_value);
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin : rx_side
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_given) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_given++;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    // weight mix: zeros, light, heavy and over-scale entries
    function automatic logic [msm_pkg::WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return '0;
        if (r < 70) return msm_pkg::WEIGHT_W'($urandom_range(1, 1250));
        if (r < 95) return msm_pkg::WEIGHT_W'($urandom_range(1251, 5000));
        return msm_pkg::WEIGHT_W'($urandom_range(10000, 16383));
    endfunction

    // offer one word; returns at the edge that accepts it, valid still high
    task automatic send_word(msm_pkg::t_action act, logic [msm_pkg::STATE_W-1:0] from_st,
                             logic [msm_pkg::STATE_W-1:0] to_st,
                             logic [msm_pkg::WEIGHT_W-1:0] w,
                             logic [msm_pkg::DRAW_W-1:0] draw);
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= act;
        in_if.from_state   <= from_st;
        in_if.to_state     <= to_st;
        in_if.weight       <= w;
        in_if.random_value <= draw;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // start/step with random don't-care fields
    task automatic sample_word(msm_pkg::t_action act, logic [msm_pkg::DRAW_W-1:0] draw);
        send_word(act, msm_pkg::STATE_W'($urandom_range(0, 15)),
                  msm_pkg::STATE_W'($urandom_range(0, 15)),
                  msm_pkg::WEIGHT_W'($urandom_range(0, 16383)), draw);
    endtask

    task automatic load_word(msm_pkg::t_action act, int from_st, int to_st, int w);
        send_word(act, msm_pkg::STATE_W'(from_st), msm_pkg::STATE_W'(to_st),
                  msm_pkg::WEIGHT_W'(w), msm_pkg::DRAW_W'($urandom_range(0, 16383)));
    endtask

    // stop offering, wait for every owed sample, then let the scan wind down
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(logic [msm_pkg::COUNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_count(v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly start-then-step chains, with loads mixed in
    task automatic random_phase(int words);
        int                         r;
        msm_pkg::t_action           act;
        logic [msm_pkg::DRAW_W-1:0] draw;
        for (int k = 0; k < words; k++) begin
            r = $urandom_range(0, 99);
            draw = ($urandom_range(0, 9) == 0)
                 ? msm_pkg::DRAW_W'($urandom_range(10000, 16383))
                 : msm_pkg::DRAW_W'($urandom_range(0, 9999));
            if (r < 12)
                load_word(msm_pkg::ACT_LOAD_TRANS, $urandom_range(0, 15),
                          $urandom_range(0, 15), pick_weight());
            else if (r < 18)
                load_word(msm_pkg::ACT_LOAD_INIT, $urandom_range(0, 15),
                          $urandom_range(0, 15), pick_weight());
            else begin
                act = (r < 30) ? msm_pkg::ACT_START : msm_pkg::ACT_STEP;
                sample_word(act, draw);
            end
        end
    endtask

    initial begin : main
        logic [msm_pkg::COUNT_W-1:0] phase_counts [8];
        phase_counts = '{5'd16, 5'd3, 5'd31, 5'd5, 5'd8, 5'd17, 5'd1, 5'd16};

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        in_if.valid        = 1'b0;
        in_if.action       = msm_pkg::ACT_LOAD_TRANS;
        in_if.from_state   = '0;
        in_if.to_state     = '0;
        in_if.weight       = '0;
        in_if.random_value = '0;
        tx_idle_on         = 1'b1;
        rx_idle_on         = 1'b1;
        hold_asked         = 0;
        hold_given         = 0;
        cycles             = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every table entry written before anything is sampled
        write_count(5'd16);
        for (int r = 0; r < MAX_STATES; r++)
            for (int c = 0; c < MAX_STATES; c++)
                load_word(msm_pkg::ACT_LOAD_TRANS, r, c, pick_weight());
        for (int c = 0; c < MAX_STATES; c++)
            load_word(msm_pkg::ACT_LOAD_INIT, $urandom_range(0, 15), c, pick_weight());

        // full count: weight extremes and out-of-range draws
        load_word(msm_pkg::ACT_LOAD_TRANS, 15, 15, 16383);
        load_word(msm_pkg::ACT_LOAD_TRANS, 15, 0, 10000);
        load_word(msm_pkg::ACT_LOAD_INIT, 0, 15, 0);
        sample_word(msm_pkg::ACT_START, 14'd16383);
        sample_word(msm_pkg::ACT_START, 14'd10000);
        sample_word(msm_pkg::ACT_START, 14'd0);
        sample_word(msm_pkg::ACT_START, 14'd9999);
        sample_word(msm_pkg::ACT_STEP, 14'd0);
        sample_word(msm_pkg::ACT_STEP, 14'd9999);
        sample_word(msm_pkg::ACT_STEP, 14'd16383);
        settle();

        // two states: land on state 1
        write_count(5'd2);
        load_word(msm_pkg::ACT_LOAD_INIT, 0, 0, 0);
        load_word(msm_pkg::ACT_LOAD_INIT, 0, 1, 10000);
        sample_word(msm_pkg::ACT_START, 14'd0);
        settle();

        // one state while current state is 1: step reads a row beyond the count
        write_count(5'd1);
        sample_word(msm_pkg::ACT_STEP, 14'd5);
        load_word(msm_pkg::ACT_LOAD_TRANS, 0, 0, 0);
        sample_word(msm_pkg::ACT_START, 14'd9999);
        sample_word(msm_pkg::ACT_STEP, 14'd0);
        settle();

        // zero states: nothing scanned
        write_count(5'd0);
        sample_word(msm_pkg::ACT_START, 14'd0);
        sample_word(msm_pkg::ACT_STEP, 14'd9999);
        settle();

        // count above the table size is capped
        write_count(5'd31);
        load_word(msm_pkg::ACT_LOAD_INIT, 0, 0, 3000);
        sample_word(msm_pkg::ACT_START, 14'd2999);
        sample_word(msm_pkg::ACT_STEP, 14'd4321);
        settle();

        // random phases; the first one starves the receiver for a while
        for (int p = 0; p < 8; p++) begin
            write_count(phase_counts[p]);
            if (p == 0) hold_asked++;
            if (p == 7) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            random_phase(PHASE_WORDS);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
